// File: hdl/circle_oriented_box_hit_macros.svh
// Assertion macros shared by the hit test block.
`ifndef CIRCLE_ORIENTED_BOX_HIT_MACROS_SVH
`define CIRCLE_ORIENTED_BOX_HIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cobh_pkg.sv
`timescale 1ns / 1ps
package cobh_pkg;

  // The angle has 1024 steps a turn, 256 to a quarter, and the quarter wave
  // is read at every step from 0 to 256, so it needs 257 entries.
  localparam int unsigned QUARTER_STEPS = 256;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_SELF   = 2'd1,
    CFG_COUNT  = 2'd2
  } cobh_cfg_t;

  typedef enum logic {
    CMD_TEST  = 1'b0,
    CMD_CLEAR = 1'b1
  } cobh_cmd_t;

  typedef logic [14:0] sin_tab_t [0:QUARTER_STEPS];

  // Word handed from the front to the back through the middle queue.
  typedef struct packed {
    logic               clear;
    logic [2:0]         idx;
    logic signed [18:0] dx;
    logic signed [18:0] dy;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [8:0]         sin_addr;
    logic               sin_neg;
    logic [8:0]         cos_addr;
    logic               cos_neg;
  } cobh_item_t;

  // Geometry verdict handed to the mark stage.
  typedef struct packed {
    logic       clear;
    logic [2:0] idx;
    logic       overlap;
  } cobh_geo_t;

  typedef struct packed {
    logic overlap;
    logic new_hit;
    logic already_hit;
  } cobh_res_t;

  // Q1.14 sine of a quarter-wave point, from a Taylor series in Q30.
  function automatic logic [14:0] sin_entry(int unsigned j);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    x = (PI_HALF_Q30 * 64'(j)) / QUARTER_STEPS;
    sum = x;
    term = (((x * x) >> 30) * x) >> 30;
    term = term / 64'd6;
    sum = (sum >= term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd20;
    sum = sum + term;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd42;
    sum = (sum >= term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd72;
    sum = sum + term;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd110;
    sum = (sum >= term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd156;
    sum = sum + term;
    v = (sum + 64'd32768) >> 16;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return 15'(v);
  endfunction

  function automatic sin_tab_t sin_table_build();
    sin_tab_t t;
    for (int unsigned j = 0; j <= QUARTER_STEPS; j++) begin
      t[j] = sin_entry(j);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TABLE = sin_table_build();

endpackage

// File: hdl/cobh_fifo.sv
`timescale 1ns / 1ps
module cobh_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/cobh_front.sv
`timescale 1ns / 1ps
module cobh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_command,
  input  logic [2:0]          in_target_index,
  input  logic signed [15:0]  in_box_left,
  input  logic signed [15:0]  in_box_top,
  input  logic [11:0]         in_box_width,
  input  logic [11:0]         in_box_height,
  input  logic [9:0]          in_box_angle,
  input  logic signed [15:0]  in_circle_x,
  input  logic signed [15:0]  in_circle_y,
  output cobh_pkg::cobh_item_t item,
  output logic                item_push,
  input  logic                item_full
);
  import cobh_pkg::*;

  cobh_item_t  item_r, item_nxt;
  logic        vld_r, vld_nxt;
  logic        accept;
  logic [1:0]  quad, quad_cos;
  logic [7:0]  step;
  logic [18:0] cx2, cy2, lx2, ty2;

  assign in_full   = vld_r && item_full;
  assign accept    = in_push && !in_full;
  assign item_push = vld_r && !item_full;
  assign item      = item_r;

  assign quad     = in_box_angle[9:8];
  assign quad_cos = quad + 2'd1;
  assign step     = in_box_angle[7:0];

  // Positions in half pixels, so the box centre stays on the grid.
  assign cx2 = {{2{in_circle_x[15]}}, in_circle_x, 1'b0};
  assign cy2 = {{2{in_circle_y[15]}}, in_circle_y, 1'b0};
  assign lx2 = {{2{in_box_left[15]}}, in_box_left, 1'b0};
  assign ty2 = {{2{in_box_top[15]}}, in_box_top, 1'b0};

  always_comb begin
    item_nxt          = item_r;
    item_nxt.clear    = (cobh_cmd_t'(in_command) == CMD_CLEAR);
    item_nxt.idx      = in_target_index;
    item_nxt.dx       = $signed(cx2 - lx2 - {7'd0, in_box_width});
    item_nxt.dy       = $signed(cy2 - ty2 - {7'd0, in_box_height});
    item_nxt.w        = in_box_width;
    item_nxt.h        = in_box_height;
    // Odd quadrants run the quarter wave backwards; the upper half is negative.
    item_nxt.sin_addr = quad[0] ? 9'd256 - {1'b0, step} : {1'b0, step};
    item_nxt.sin_neg  = quad[1];
    item_nxt.cos_addr = quad_cos[0] ? 9'd256 - {1'b0, step} : {1'b0, step};
    item_nxt.cos_neg  = quad_cos[1];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (item_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: hdl/cobh_geom.sv
`timescale 1ns / 1ps
module cobh_geom (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [11:0]          radius,
  input  cobh_pkg::cobh_item_t item,
  input  logic                 item_empty,
  output logic                 item_pop,
  output logic                 geo_v,
  output cobh_pkg::cobh_geo_t  geo,
  input  logic                 res_full
);
  import cobh_pkg::*;

  typedef struct packed {
    logic       clear;
    logic [2:0] idx;
    logic [11:0] w;
    logic [11:0] h;
  } tag_t;

  typedef struct packed {
    logic       clear;
    logic [2:0] idx;
  } id_t;

  logic adv;

  // Stage 1: quarter-wave table reads.
  logic        s1_v_r;
  cobh_item_t  s1_r;
  logic [14:0] sin_mag_r, cos_mag_r;
  // Stage 2: rotation products.
  logic               s2_v_r;
  tag_t               s2_r;
  logic signed [32:0] pcx_r, psy_r, pcy_r, psx_r;
  // Stage 3: box-frame coordinates.
  logic               s3_v_r;
  tag_t               s3_r;
  logic signed [33:0] lx_r, ly_r;
  // Stage 4: excess beyond the half extents.
  logic        s4_v_r;
  id_t         s4_r;
  logic [33:0] ex_r, ey_r;
  // Stage 5: squares and the per-axis early out.
  logic        s5_v_r;
  id_t         s5_r;
  logic [53:0] sqx_r, sqy_r;
  logic        far_r;
  // Stage 6: verdict.
  logic        s6_v_r;
  cobh_geo_t   s6_r;

  logic [23:0] rad_sq_r;

  logic signed [15:0] sin_s, cos_s;
  logic signed [34:0] m_cx, m_sy, m_cy, m_sx;
  logic [25:0]        hx, hy;
  logic signed [34:0] dx1, dx2, dy1, dy2;
  logic [33:0]        ex_nxt, ey_nxt;
  logic [26:0]        rr;
  logic               far_nxt;
  logic [54:0]        sq_sum;
  logic [54:0]        rr_sq;
  cobh_geo_t          s6_nxt;

  // The whole back end holds while a verdict waits on a full result queue.
  assign adv      = !(s6_v_r && res_full);
  assign item_pop = adv && !item_empty;
  assign geo_v    = s6_v_r;
  assign geo      = s6_r;

  assign sin_s = s1_r.sin_neg ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
  assign cos_s = s1_r.cos_neg ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});
  assign m_cx  = cos_s * s1_r.dx;
  assign m_sy  = sin_s * s1_r.dy;
  assign m_cy  = cos_s * s1_r.dy;
  assign m_sx  = sin_s * s1_r.dx;

  assign hx  = {s3_r.w, 14'd0};
  assign hy  = {s3_r.h, 14'd0};
  assign dx1 = 35'(lx_r) - $signed({9'd0, hx});
  assign dx2 = -35'(lx_r) - $signed({9'd0, hx});
  assign dy1 = 35'(ly_r) - $signed({9'd0, hy});
  assign dy2 = -35'(ly_r) - $signed({9'd0, hy});

  always_comb begin
    ex_nxt = '0;
    ey_nxt = '0;
    if (dx1 > 35'sd0) begin
      ex_nxt = dx1[33:0];
    end else if (dx2 > 35'sd0) begin
      ex_nxt = dx2[33:0];
    end
    if (dy1 > 35'sd0) begin
      ey_nxt = dy1[33:0];
    end else if (dy2 > 35'sd0) begin
      ey_nxt = dy2[33:0];
    end
  end

  assign rr      = {radius, 15'd0};
  assign far_nxt = (ex_r >= 34'(rr)) || (ey_r >= 34'(rr));

  assign sq_sum = 55'(sqx_r) + 55'(sqy_r);
  assign rr_sq  = 55'({rad_sq_r, 30'd0});

  always_comb begin
    s6_nxt         = '0;
    s6_nxt.clear   = s5_r.clear;
    s6_nxt.idx     = s5_r.idx;
    s6_nxt.overlap = !s5_r.clear && !far_r && (sq_sum < rr_sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= !item_empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rad_sq_r <= radius * radius;
    if (adv) begin
      s1_r      <= item;
      sin_mag_r <= SIN_TABLE[item.sin_addr];
      cos_mag_r <= SIN_TABLE[item.cos_addr];

      s2_r  <= '{clear: s1_r.clear, idx: s1_r.idx, w: s1_r.w, h: s1_r.h};
      pcx_r <= m_cx[32:0];
      psy_r <= m_sy[32:0];
      pcy_r <= m_cy[32:0];
      psx_r <= m_sx[32:0];

      s3_r <= s2_r;
      lx_r <= 34'(pcx_r) + 34'(psy_r);
      ly_r <= 34'(pcy_r) - 34'(psx_r);

      s4_r <= '{clear: s3_r.clear, idx: s3_r.idx};
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;

      // Only the low bits matter once the excess is below the radius.
      s5_r  <= s4_r;
      sqx_r <= ex_r[26:0] * ex_r[26:0];
      sqy_r <= ey_r[26:0] * ey_r[26:0];
      far_r <= far_nxt;

      s6_r <= s6_nxt;
    end
  end

endmodule

// File: hdl/cobh_marks.sv
`timescale 1ns / 1ps
module cobh_marks #(
  parameter int unsigned MAX_TARGETS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2:0]             self_index,
  input  logic [3:0]             target_count,
  input  logic                   geo_v,
  input  cobh_pkg::cobh_geo_t    geo,
  input  logic                   res_full,
  output logic                   res_push,
  output cobh_pkg::cobh_res_t    res,
  output logic [MAX_TARGETS-1:0] marks
);
  import cobh_pkg::*;

  logic [MAX_TARGETS-1:0] marks_r, marks_nxt;
  logic [MAX_TARGETS-1:0] bit_sel;
  logic                   in_range, marked, valid_tgt, fresh;

  assign res_push  = geo_v && !res_full;
  assign marks     = marks_r;
  assign bit_sel   = MAX_TARGETS'(1) << geo.idx;
  assign in_range  = (int'(geo.idx) < MAX_TARGETS);
  assign marked    = in_range && ((marks_r & bit_sel) != '0);
  assign valid_tgt = in_range && ({1'b0, geo.idx} < target_count) &&
                     (geo.idx != self_index);
  assign fresh     = !geo.clear && geo.overlap && valid_tgt && !marked;

  always_comb begin
    res             = '0;
    res.overlap     = geo.overlap;
    res.new_hit     = fresh;
    res.already_hit = !geo.clear && marked;
  end

  always_comb begin
    marks_nxt = marks_r;
    if (res_push) begin
      if (geo.clear) begin
        marks_nxt = '0;
      end else if (fresh) begin
        marks_nxt = marks_r | bit_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else begin
      marks_r <= marks_nxt;
    end
  end

endmodule

// File: hdl/circle_oriented_box_hit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                | Word
// in_      | input     | in_push / in_full        | command, target, box, circle centre
// out_     | output    | out_pop / out_empty      | overlap, new_hit, already_hit
// cfg_     | input     | cfg_we                   | cfg_index, cfg_data
//
// One test a cycle is sustained while the result queue is not full; a word
// passes the front register, the middle queue and the six-stage geometry
// pipeline (table read, rotation multiply, sum, clamp, square, compare)
// before it is written to the result queue. Reset is synchronous and leaves
// every hit mark clear. A full result queue holds the geometry pipeline,
// which then backs up through the middle queue to in_full.
module circle_oriented_box_hit #(
  parameter int unsigned MAX_TARGETS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_command,
  input  logic [2:0]         in_target_index,
  input  logic signed [15:0] in_box_left,
  input  logic signed [15:0] in_box_top,
  input  logic [11:0]        in_box_width,
  input  logic [11:0]        in_box_height,
  input  logic [9:0]         in_box_angle,
  input  logic signed [15:0] in_circle_x,
  input  logic signed [15:0] in_circle_y,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_overlap,
  output logic               out_new_hit,
  output logic               out_already_hit
);
  import cobh_pkg::*;
`include "circle_oriented_box_hit_macros.svh"

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  logic [11:0] radius_r;
  logic [2:0]  self_r;
  logic [3:0]  count_r;

  cobh_item_t             front_item, mid_item;
  logic                   front_push, mid_full, mid_empty, mid_pop;
  logic                   geo_v;
  cobh_geo_t              geo;
  logic                   res_push, res_full;
  cobh_res_t              res, res_out;
  logic [MAX_TARGETS-1:0] marks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 12'd150;
      self_r   <= 3'd0;
      count_r  <= 4'd4;
    end else if (cfg_we) begin
      case (cobh_cfg_t'(cfg_index))
        CFG_RADIUS: radius_r <= cfg_data;
        CFG_SELF:   self_r   <= cfg_data[2:0];
        CFG_COUNT:  count_r  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  cobh_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_target_index (in_target_index),
    .in_box_left     (in_box_left),
    .in_box_top      (in_box_top),
    .in_box_width    (in_box_width),
    .in_box_height   (in_box_height),
    .in_box_angle    (in_box_angle),
    .in_circle_x     (in_circle_x),
    .in_circle_y     (in_circle_y),
    .item            (front_item),
    .item_push       (front_push),
    .item_full       (mid_full)
  );

  cobh_fifo #(
    .WIDTH ($bits(cobh_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  cobh_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .radius     (radius_r),
    .item       (mid_item),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .geo_v      (geo_v),
    .geo        (geo),
    .res_full   (res_full)
  );

  cobh_marks #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_marks (
    .clk          (clk),
    .rst_n        (rst_n),
    .self_index   (self_r),
    .target_count (count_r),
    .geo_v        (geo_v),
    .geo          (geo),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res),
    .marks        (marks)
  );

  cobh_fifo #(
    .WIDTH ($bits(cobh_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_overlap     = res_out.overlap;
  assign out_new_hit     = res_out.new_hit;
  assign out_already_hit = res_out.already_hit;

  // A clear word leaving the mark stage must leave no target marked.
  `COBH_ASSERT_NXT(a_clear_empties_marks, res_push && geo.clear, marks == '0, "clear left marks set")
  // A fresh hit must leave its target marked.
  `COBH_ASSERT_NXT(a_hit_sets_mark, res_push && res.new_hit, ((marks >> $past(geo.idx)) & MAX_TARGETS'(1)) != '0, "hit did not set its mark")
  // While a verdict is held by a full result queue, nothing enters the pipeline.
  `COBH_ASSERT_IMP(a_stall_holds_queue, geo_v && res_full, !mid_pop, "queue popped during a stall")

endmodule
